>>> rtl/bounded_positional_list_macros.svh
// Assertion macros used by the bounded positional list top level.
// Expects clk and rst_n in the including module's scope.
`ifndef BOUNDED_POSITIONAL_LIST_MACROS_SVH
`define BOUNDED_POSITIONAL_LIST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPL_ASSERT_NOW(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("bounded positional list check failed");

// Next-cycle implication, disabled during reset.
`define BPL_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("bounded positional list check failed");

`endif

>>> rtl/bpl_pkg.sv
// Package for the bounded positional list: field widths, op and status codes,
// and the per-cell control struct. No dependencies.
package bpl_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int POS_W  = 5;
    localparam int ST_W   = 3;

    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS  = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_HEAD = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_TAIL = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_POS  = 3'd5;
    localparam logic [OP_W-1:0] OP_SEARCH   = 3'd6;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
        logic compare;
    } cell_ctrl_t;

endpackage

>>> rtl/bounded_positional_list.sv
// Bounded positional list top level: request decode, count, chain of cells, result register.
// Depends on bpl_pkg, bpl_cell and bounded_positional_list_macros.svh.
//
// The block serves one request at a time. An insert or delete is accepted, then in the
// execute state every cell of the chain shifts toward or away from the target slot in
// parallel as the result register is loaded. A search is accepted, then all cells compare
// against the value at once in the execute state; in the find state a priority encoder
// over the registered match flags picks the first hit as the result register is loaded.
// The result register lets a new request be accepted while the previous result still
// waits; the next result is held back until that one is taken, which stretches the
// request by the cycles the receiver stalls. No clearing pass after reset.
`include "bounded_positional_list_macros.svh"

module bounded_positional_list
    import bpl_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OP_W-1:0]          op,
    input  logic signed [DATA_W-1:0] value,
    input  logic [POS_W-1:0]         position,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [ST_W-1:0]          status,
    output logic signed [DATA_W-1:0] result_value,
    output logic [POS_W-1:0]         found_position,
    output logic [POS_W-1:0]         entry_count
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FIND = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] value_reg;
    logic [POS_W-1:0]  position_reg;

    logic [ST_W-1:0]   status_reg;
    logic [ST_W-1:0]   status_next;
    logic [DATA_W-1:0] result_reg;
    logic [DATA_W-1:0] result_next;
    logic [POS_W-1:0]  fpos_reg;
    logic [POS_W-1:0]  fpos_next;
    logic [POS_W-1:0]  ecount_reg;
    logic [POS_W-1:0]  ecount_next;

    logic              out_free;
    logic              exec_go;
    logic              do_ins;
    logic              do_del;
    logic [WW-1:0]     k_w;
    logic [IW-1:0]     k;
    logic [ST_W-1:0]   ex_status;
    logic [WW-1:0]     count_w;
    logic [WW-1:0]     pos_w;
    logic [CW-1:0]     count_upd;
    logic [WW-1:0]     count_next_w;
    logic [POS_W-1:0]  count_low;
    logic              hit;
    logic [IW-1:0]     hit_idx;
    logic [WW-1:0]     hit_pos_w;

    cell_ctrl_t        cell_ctrl [CAPACITY];
    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] left_in   [CAPACITY];
    logic [DATA_W-1:0] right_in  [CAPACITY];
    logic              cell_live [CAPACITY];
    logic              cell_match[CAPACITY];

    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign exec_go  = (state_reg == S_EXEC) && out_free && (op_reg != OP_SEARCH);

    assign count_w   = {{(WW-CW){1'b0}}, count_reg};
    assign pos_w     = {{(WW-POS_W){1'b0}}, position_reg};
    assign count_low = count_w[POS_W-1:0];
    assign k         = k_w[IW-1:0];

    // decode the captured request against the current count
    always_comb
    begin
        do_ins    = 1'b0;
        do_del    = 1'b0;
        k_w       = '0;
        ex_status = ST_OK;
        case (op_reg)
            OP_INS_HEAD, OP_INS_TAIL:
            begin
                if (count_w >= WW'(CAPACITY))
                begin
                    ex_status = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                    k_w    = (op_reg == OP_INS_HEAD) ? '0 : count_w;
                end
            end
            OP_INS_POS:
            begin
                if (count_w == '0)
                begin
                    ex_status = ST_EMPTY;
                end
                else if (count_w >= WW'(CAPACITY))
                begin
                    ex_status = ST_FULL;
                end
                else if ((pos_w == '0) || (pos_w > (count_w + WW'(1))))
                begin
                    ex_status = ST_BADPOS;
                end
                else
                begin
                    do_ins = 1'b1;
                    k_w    = pos_w - WW'(1);
                end
            end
            OP_DEL_HEAD, OP_DEL_TAIL:
            begin
                if (count_w == '0)
                begin
                    ex_status = ST_EMPTY;
                end
                else
                begin
                    do_del = 1'b1;
                    k_w    = (op_reg == OP_DEL_HEAD) ? '0 : (count_w - WW'(1));
                end
            end
            OP_DEL_POS:
            begin
                if (count_w == '0)
                begin
                    ex_status = ST_EMPTY;
                end
                else if ((pos_w == '0) || (pos_w > count_w))
                begin
                    ex_status = ST_BADPOS;
                end
                else
                begin
                    do_del = 1'b1;
                    k_w    = pos_w - WW'(1);
                end
            end
            default:
            begin
                ex_status = ST_OK;
            end
        endcase
    end

    // chain of cells
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign left_in[g] = value_reg;
            end
            else
            begin : g_mid_l
                assign left_in[g] = cell_data[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_in[g] = cell_data[g];
            end
            else
            begin : g_mid_r
                assign right_in[g] = cell_data[g+1];
            end

            assign cell_live[g]            = (CW'(g) < count_reg);
            assign cell_ctrl[g].load       = exec_go && do_ins && (k == IW'(g));
            assign cell_ctrl[g].take_left  = exec_go && do_ins && (IW'(g) > k);
            assign cell_ctrl[g].take_right = exec_go && do_del && (IW'(g) >= k);
            assign cell_ctrl[g].compare    = (state_reg == S_EXEC) && (op_reg == OP_SEARCH);

            bpl_cell u_cell
            (
                .clk        (clk),
                .ctrl       (cell_ctrl[g]),
                .live       (cell_live[g]),
                .left_data  (left_in[g]),
                .right_data (right_in[g]),
                .req_value  (value_reg),
                .data       (cell_data[g]),
                .match      (cell_match[g])
            );
        end
    endgenerate

    // first match wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (cell_match[i])
            begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
        end
    end

    assign hit_pos_w = {{(WW-IW){1'b0}}, hit_idx} + WW'(1);

    assign count_upd    = do_ins ? (count_reg + CW'(1)) :
                          do_del ? (count_reg - CW'(1)) : count_reg;
    assign count_next_w = {{(WW-CW){1'b0}}, count_upd};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        result_next    = result_reg;
        fpos_next      = fpos_reg;
        ecount_next    = ecount_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (op_reg == OP_SEARCH)
                begin
                    state_next = S_FIND;
                end
                else if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = ex_status;
                    result_next    = do_del ? cell_data[k] : '0;
                    fpos_next      = '0;
                    count_next     = count_upd;
                    ecount_next    = count_next_w[POS_W-1:0];
                end
            end
            S_FIND:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = hit ? ST_OK : ST_NOTFOUND;
                    result_next    = hit ? value_reg : '0;
                    fpos_next      = hit ? hit_pos_w[POS_W-1:0] : '0;
                    ecount_next    = count_low;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the request and the result payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg       <= op;
            value_reg    <= value;
            position_reg <= position;
        end
        status_reg <= status_next;
        result_reg <= result_next;
        fpos_reg   <= fpos_next;
        ecount_reg <= ecount_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign result_value   = result_reg;
    assign found_position = fpos_reg;
    assign entry_count    = ecount_reg;

    `BPL_ASSERT_NOW(a_count_bound, 1'b1, count_w <= WW'(CAPACITY))
    `BPL_ASSERT_NEXT(a_count_hold, state_reg != S_EXEC, $stable(count_reg))
    `BPL_ASSERT_NOW(a_out_count, out_valid_reg, ecount_reg == count_low)
    `BPL_ASSERT_NOW(a_fpos_clear, out_valid_reg && (status_reg != ST_OK), fpos_reg == '0)

endmodule

>>> rtl/bpl_cell.sv
// One storage cell of the list chain: holds one entry and a match flag.
// Depends on bpl_pkg.
module bpl_cell
    import bpl_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic              live,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    input  logic [DATA_W-1:0] req_value,
    output logic [DATA_W-1:0] data,
    output logic              match
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              match_reg;
    logic              match_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = req_value;
        end
        else if (ctrl.take_left)
        begin
            data_next = left_data;
        end
        else if (ctrl.take_right)
        begin
            data_next = right_data;
        end
        match_next = ctrl.compare ? (live && (data_reg == req_value)) : match_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

>>> tb/tb_bounded_positional_list.sv
`timescale 1ns / 100ps
// Testbench for bounded_positional_list: directed and random list requests, with a
// queue-based list predictor and result checking. Depends on bpl_pkg and the RTL.
module tb_bounded_positional_list;
    import bpl_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 1230;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [OP_W-1:0]          OP_UNUSED = 3'd7;
    localparam logic signed [DATA_W-1:0] VAL_MIN   = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX   = 32'sh7fff_ffff;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] result_value;
        logic [POS_W-1:0]         found_position;
        logic [POS_W-1:0]         entry_count;
    } list_result_t;

    class list_scoreboard;
        logic signed [DATA_W-1:0] contents[$];
        list_result_t             awaited[$];
        int                       errors;
        int                       checked;
        int                       full_hits;
        int                       empty_hits;

        function new();
            errors     = 0;
            checked    = 0;
            full_hits  = 0;
            empty_hits = 0;
        endfunction

        function void note_request(input logic [OP_W-1:0] req_op,
                                   input logic signed [DATA_W-1:0] req_value,
                                   input logic [POS_W-1:0] req_pos);
            list_result_t res;
            int           n;
            int           p;
            n   = contents.size();
            p   = int'(req_pos);
            res = '0;
            res.status = ST_OK;
            case (req_op)
                OP_INS_HEAD, OP_INS_TAIL:
                begin
                    if (n >= CAPACITY)
                        res.status = ST_FULL;
                    else if (req_op == OP_INS_HEAD)
                        contents.push_front(req_value);
                    else
                        contents.push_back(req_value);
                end
                OP_INS_POS:
                begin
                    if (n == 0)
                        res.status = ST_EMPTY;
                    else if (n >= CAPACITY)
                        res.status = ST_FULL;
                    else if (p < 1 || p > n + 1)
                        res.status = ST_BADPOS;
                    else
                        contents.insert(p - 1, req_value);
                end
                OP_DEL_HEAD, OP_DEL_TAIL:
                begin
                    if (n == 0)
                        res.status = ST_EMPTY;
                    else if (req_op == OP_DEL_HEAD)
                        res.result_value = contents.pop_front();
                    else
                        res.result_value = contents.pop_back();
                end
                OP_DEL_POS:
                begin
                    if (n == 0)
                        res.status = ST_EMPTY;
                    else if (p < 1 || p > n)
                        res.status = ST_BADPOS;
                    else
                    begin
                        res.result_value = contents[p - 1];
                        contents.delete(p - 1);
                    end
                end
                OP_SEARCH:
                begin
                    res.status = ST_NOTFOUND;
                    for (int i = 0; i < n; i++)
                    begin
                        if (res.status == ST_NOTFOUND && contents[i] == req_value)
                        begin
                            res.status         = ST_OK;
                            res.result_value   = req_value;
                            res.found_position = POS_W'(i + 1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
            res.entry_count = POS_W'(contents.size());
            if (res.status == ST_FULL)
                full_hits++;
            if (res.status == ST_EMPTY)
                empty_hits++;
            awaited.push_back(res);
        endfunction

        task report_mismatch(input string field, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] exp);
            $display("MISMATCH result %0d: %s got %0h expected %0h", checked, field, got, exp);
            errors++;
        endtask

        task check_result(input list_result_t got);
            list_result_t exp;
            if (awaited.size() == 0)
            begin
                report_mismatch("unrequested result", got.status, '0);
            end
            else
            begin
                exp = awaited.pop_front();
                if (got.status !== exp.status)
                    report_mismatch("status", got.status, exp.status);
                if (got.result_value !== exp.result_value)
                    report_mismatch("result_value", got.result_value, exp.result_value);
                if (got.found_position !== exp.found_position)
                    report_mismatch("found_position", got.found_position, exp.found_position);
                if (got.entry_count !== exp.entry_count)
                    report_mismatch("entry_count", got.entry_count, exp.entry_count);
            end
            checked++;
        endtask
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic                     out_valid;
    logic                     out_ready;
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] result_value;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         entry_count;

    list_scoreboard sb;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             requests_sent;
    int             stall_cycles;
    bit             growing;

    bounded_positional_list #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .value         (value),
        .position      (position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .result_value  (result_value),
        .found_position(found_position),
        .entry_count   (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic apply_request(input logic [OP_W-1:0] req_op,
                                 input logic signed [DATA_W-1:0] req_value,
                                 input logic [POS_W-1:0] req_pos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= req_op;
        value    <= req_value;
        position <= req_pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(req_op, req_value, req_pos);
        requests_sent++;
    endtask

    task automatic random_request();
        int                       n;
        int                       roll;
        logic [OP_W-1:0]          req_op;
        logic signed [DATA_W-1:0] req_value;
        logic [POS_W-1:0]         req_pos;
        n = sb.contents.size();
        // steer the fill level so both full and empty lists come up often
        if (n == CAPACITY && $urandom_range(3) == 0)
            growing = 1'b0;
        else if (n == 0 && $urandom_range(3) == 0)
            growing = 1'b1;
        else if ($urandom_range(29) == 0)
            growing = ~growing;
        roll = $urandom_range(99);
        if (roll < 2)
            req_op = OP_UNUSED;
        else if (roll < 22)
            req_op = OP_SEARCH;
        else if (($urandom_range(99) < 75) == growing)
            req_op = OP_W'($urandom_range(int'(OP_INS_POS), int'(OP_INS_HEAD)));
        else
            req_op = OP_W'($urandom_range(int'(OP_DEL_POS), int'(OP_DEL_HEAD)));
        if ($urandom_range(9) < 8)
            req_pos = POS_W'($urandom_range(n + 1, 1));
        else
            req_pos = POS_W'($urandom_range(31, 0));
        case ($urandom_range(3))
            0: req_value = $signed(DATA_W'($urandom_range(7))) - 3;
            1:
            begin
                case ($urandom_range(3))
                    0: req_value = VAL_MIN;
                    1: req_value = VAL_MAX;
                    2: req_value = '0;
                    default: req_value = -1;
                endcase
            end
            default: req_value = $signed($urandom);
        endcase
        if (req_op == OP_SEARCH && n > 0 && $urandom_range(9) < 6)
            req_value = sb.contents[$urandom_range(n - 1)];
        apply_request(req_op, req_value, req_pos);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(list_result_t'{status, result_value, found_position, entry_count});
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = OP_INS_HEAD;
        value         = '0;
        position      = '0;
        out_ready     = 1'b0;
        send_idle_pct = 32;
        recv_idle_pct = 78;
        requests_sent = 0;
        stall_cycles  = 0;
        growing       = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list
        apply_request(OP_DEL_HEAD, 0, 0);
        apply_request(OP_DEL_TAIL, 0, 0);
        apply_request(OP_DEL_POS, 0, 1);
        apply_request(OP_INS_POS, 5, 1);
        apply_request(OP_SEARCH, 0, 0);
        apply_request(OP_UNUSED, -1, 31);
        // extremes, head and append positions, bad positions
        apply_request(OP_INS_HEAD, VAL_MIN, 0);
        apply_request(OP_INS_TAIL, VAL_MAX, 31);
        apply_request(OP_INS_POS, 7, 1);
        apply_request(OP_INS_POS, -1, 4);
        apply_request(OP_INS_POS, 9, 0);
        apply_request(OP_INS_POS, 9, 6);
        apply_request(OP_SEARCH, VAL_MAX, 0);
        apply_request(OP_SEARCH, 12345, 0);
        apply_request(OP_DEL_POS, 0, 0);
        apply_request(OP_DEL_POS, 0, 5);
        apply_request(OP_DEL_POS, 0, 2);
        // fill up, then hit the full list
        for (int i = 0; i < CAPACITY - 3; i++)
            apply_request(OP_INS_TAIL, i, 0);
        apply_request(OP_INS_HEAD, 1, 0);
        apply_request(OP_INS_TAIL, 2, 0);
        apply_request(OP_INS_POS, 3, 1);
        apply_request(OP_SEARCH, 7, 0);
        apply_request(OP_SEARCH, CAPACITY - 4, 0);
        apply_request(OP_DEL_TAIL, 0, 0);
        apply_request(OP_DEL_HEAD, 0, 0);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 78 : 0;
            recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 32 : 0;
            repeat (RANDOM_ITEMS / 3)
                random_request();
        end
        in_valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d requests, %0d results checked, %0d mismatches",
                 requests_sent, sb.checked, sb.errors);
        $display("Run: full-list refusals %0d, empty-list refusals %0d",
                 sb.full_hits, sb.empty_hits);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
